@@ rtl/mmrc_pkg.sv @@
package mmrc_pkg;

    // Field widths of the descriptor and region beats
    localparam int unsigned TYPE_W     = 8;
    localparam int unsigned START_W    = 52;
    localparam int unsigned DPAGES_W   = 40;
    localparam int unsigned PAGES_W    = 44;
    localparam int unsigned MB_W       = 36;

    // Defaults for the top-level parameters
    localparam int unsigned ADDR_BITS_DEF  = 52;
    localparam int unsigned PAGE_SHIFT_DEF = 12;

    // Firmware memory type codes with a class of their own
    localparam logic [TYPE_W-1:0] TYPE_BOOT_CODE    = 8'd3;
    localparam logic [TYPE_W-1:0] TYPE_BOOT_DATA    = 8'd4;
    localparam logic [TYPE_W-1:0] TYPE_CONVENTIONAL = 8'd7;
    localparam logic [TYPE_W-1:0] TYPE_MMIO         = 8'd11;

    typedef enum logic [1:0] {
        CLS_FREE = 2'd0,
        CLS_MMIO = 2'd1,
        CLS_RSVD = 2'd2
    } t_region_class;

    typedef struct packed {
        logic [TYPE_W-1:0]   desc_type;
        logic [START_W-1:0]  desc_start;
        logic [DPAGES_W-1:0] desc_pages;
        logic                last_desc;
    } t_desc;

    typedef struct packed {
        t_region_class      region_class;
        logic [START_W-1:0] region_start;
        logic [PAGES_W-1:0] region_pages;
        logic               last_region;
        logic [MB_W-1:0]    total_mb;
    } t_region;

    // Registered descriptor as seen by the merge logic
    typedef struct packed {
        logic  valid;
        t_desc desc;
    } t_in_stage;

    // Up to two regions produced by one descriptor, in emit order
    typedef struct packed {
        logic    v0;
        t_region r0;
        logic    v1;
        t_region r1;
    } t_pair;

    // Handshake between merge logic and output queue
    typedef struct packed {
        logic       adv;
        logic [1:0] cnt;
    } t_q_status;

    function automatic t_region_class class_of(input logic [TYPE_W-1:0] code);
        t_region_class cls;
        case (code)
            TYPE_BOOT_CODE:    cls = CLS_FREE;
            TYPE_BOOT_DATA:    cls = CLS_FREE;
            TYPE_CONVENTIONAL: cls = CLS_FREE;
            TYPE_MMIO:         cls = CLS_MMIO;
            default:           cls = CLS_RSVD;
        endcase
        return cls;
    endfunction

endpackage

@@ rtl/mmrc_stream_if.sv @@
interface mmrc_stream_if #(
    parameter type t_payload = logic
);
    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/mmrc_in_stage.sv @@
module mmrc_in_stage
    import mmrc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_desc       i_desc,
    output logic        o_ready,
    input  logic        i_adv,
    output t_in_stage   o_stage
);

    logic  r_valid;
    logic  n_valid;
    t_desc r_desc;

    // Take a new beat when empty or when the held one retires this cycle
    assign o_ready = !r_valid || i_adv;

    always_comb begin
        n_valid = r_valid;
        if (i_valid && o_ready) begin
            n_valid = 1'b1;
        end else if (i_adv) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_desc <= i_desc;
        end
    end

    assign o_stage.valid = r_valid;
    assign o_stage.desc  = r_desc;

endmodule

@@ rtl/mmrc_merge.sv @@
module mmrc_merge
    import mmrc_pkg::*;
#(
    parameter int unsigned ADDR_BITS  = ADDR_BITS_DEF,
    parameter int unsigned PAGE_SHIFT = PAGE_SHIFT_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_in_stage i_stage,
    input  logic      i_adv,
    output t_pair     o_pair
);

    localparam int unsigned SPAN_W = PAGES_W + PAGE_SHIFT;
    localparam int unsigned SUM_W  = ((ADDR_BITS > SPAN_W) ? ADDR_BITS : SPAN_W) + 1;
    localparam int unsigned MB_SHIFT = 20 - PAGE_SHIFT;
    localparam logic [START_W-1:0] ST_MASK = (ADDR_BITS >= START_W) ? {START_W{1'b1}} :
        START_W'((66'(1) << ADDR_BITS) - 66'(1));
    localparam logic [PAGES_W-1:0] PAGES_MAX = {PAGES_W{1'b1}};

    logic                 r_held_valid;
    t_region_class        r_held_class;
    logic [START_W-1:0]   r_held_start;
    logic [PAGES_W-1:0]   r_held_pages;
    logic [PAGES_W-1:0]   r_total;

    t_region_class        n_held_class;
    logic [START_W-1:0]   n_held_start;
    logic [PAGES_W-1:0]   n_held_pages;
    logic [PAGES_W-1:0]   n_total;

    t_region_class        cls;
    logic [START_W-1:0]   start_m;
    logic [SUM_W-1:0]     held_end;
    logic                 merge;
    logic [PAGES_W:0]     held_sum;
    logic [PAGES_W:0]     total_sum;

    assign cls     = class_of(i_stage.desc.desc_type);
    assign start_m = i_stage.desc.desc_start & ST_MASK;

    // Exact end of the held region; an end past the address space never
    // equals a masked start, so no separate overflow test is needed
    assign held_end = SUM_W'(r_held_start) + (SUM_W'(r_held_pages) << PAGE_SHIFT);
    assign merge    = r_held_valid && (r_held_class == cls) && (held_end == SUM_W'(start_m));

    assign held_sum  = {1'b0, r_held_pages} + (PAGES_W+1)'(i_stage.desc.desc_pages);
    assign total_sum = {1'b0, r_total} + (PAGES_W+1)'(i_stage.desc.desc_pages);

    always_comb begin
        if (merge) begin
            n_held_class = r_held_class;
            n_held_start = r_held_start;
            n_held_pages = held_sum[PAGES_W] ? PAGES_MAX : held_sum[PAGES_W-1:0];
        end else begin
            n_held_class = cls;
            n_held_start = start_m;
            n_held_pages = PAGES_W'(i_stage.desc.desc_pages);
        end
        if (cls != CLS_MMIO) begin
            n_total = total_sum[PAGES_W] ? PAGES_MAX : total_sum[PAGES_W-1:0];
        end else begin
            n_total = r_total;
        end
    end

    always_comb begin
        o_pair.v0              = i_stage.valid && r_held_valid && !merge;
        o_pair.r0.region_class = r_held_class;
        o_pair.r0.region_start = r_held_start;
        o_pair.r0.region_pages = r_held_pages;
        o_pair.r0.last_region  = 1'b0;
        o_pair.r0.total_mb     = '0;
        o_pair.v1              = i_stage.valid && i_stage.desc.last_desc;
        o_pair.r1.region_class = n_held_class;
        o_pair.r1.region_start = n_held_start;
        o_pair.r1.region_pages = n_held_pages;
        o_pair.r1.last_region  = 1'b1;
        o_pair.r1.total_mb     = MB_W'(n_total >> MB_SHIFT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_valid <= 1'b0;
            r_held_class <= CLS_FREE;
            r_held_start <= '0;
            r_held_pages <= '0;
            r_total      <= '0;
        end else if (i_adv) begin
            if (i_stage.desc.last_desc) begin
                r_held_valid <= 1'b0;
                r_held_class <= CLS_FREE;
                r_held_start <= '0;
                r_held_pages <= '0;
                r_total      <= '0;
            end else begin
                r_held_valid <= 1'b1;
                r_held_class <= n_held_class;
                r_held_start <= n_held_start;
                r_held_pages <= n_held_pages;
                r_total      <= n_total;
            end
        end
    end

endmodule

@@ rtl/mmrc_out_queue.sv @@
module mmrc_out_queue
    import mmrc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_pair     i_pair,
    output t_q_status o_status,
    output logic      o_valid,
    input  logic      i_ready,
    output t_region   o_region
);

    logic [1:0] r_cnt;
    logic [1:0] n_cnt;
    t_region    r_q0;
    t_region    r_q1;
    t_region    n_q0;
    t_region    n_q1;

    logic       pop;
    logic [1:0] keep;
    logic [1:0] nnew;
    logic       adv;
    t_region    e0;
    t_region    e1;

    assign pop  = (r_cnt != 2'd0) && i_ready;
    assign keep = r_cnt - {1'b0, pop};
    assign nnew = {1'b0, i_pair.v0} + {1'b0, i_pair.v1};
    assign adv  = i_in_valid && ((keep + nnew) <= 2'd2) && !(keep == 2'd2 && nnew != 2'd0);

    // Compact the new regions so the first one to emit comes first
    assign e0 = i_pair.v0 ? i_pair.r0 : i_pair.r1;
    assign e1 = i_pair.r1;

    always_comb begin
        n_q0  = r_q0;
        n_q1  = r_q1;
        n_cnt = keep;
        if (pop) begin
            n_q0 = r_q1;
        end
        if (adv) begin
            n_cnt = keep + nnew;
            case (keep)
                2'd0: begin
                    n_q0 = e0;
                    n_q1 = e1;
                end
                2'd1: begin
                    n_q1 = e0;
                end
                default: begin
                    n_q1 = r_q1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else begin
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q0 <= n_q0;
        r_q1 <= n_q1;
    end

    assign o_status.adv = adv;
    assign o_status.cnt = r_cnt;
    assign o_valid      = r_cnt != 2'd0;
    assign o_region     = r_q0;

endmodule

@@ rtl/memory_map_region_coalescer_unit.sv @@
// Memory map region coalescer.
// i_desc (sink) takes one firmware memory-map descriptor per beat: type code,
// start address, page count and a last-descriptor flag. o_region (source)
// gives merged regions: class, start, saturating page count, last flag and,
// on the last region only, the non-MMIO total in MiB.
// A descriptor that continues the held region with the same class grows it;
// any other descriptor flushes the held region and takes its place. The
// final descriptor of a map flushes the held region with last_region set and
// starts a fresh map, so one descriptor yields zero, one or two regions.
// A descriptor is accepted into the input register; once the output queue
// has room, its regions are written into the two-entry queue, whose head
// entry drives o_region.
// Throughput: one descriptor per cycle while the receiver takes each region
// and each descriptor yields at most one region; one that yields two regions
// can stall the input at the single-beat output port.
// When the receiver stalls, the queue fills, the input register holds its
// descriptor and i_desc.ready drops; nothing is lost or repeated.
// Reset (synchronous, active low) empties the input register and the queue
// and clears the held region and the running total.
module memory_map_region_coalescer_unit
    import mmrc_pkg::*;
#(
    parameter int unsigned ADDR_BITS  = ADDR_BITS_DEF,
    parameter int unsigned PAGE_SHIFT = PAGE_SHIFT_DEF
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    mmrc_stream_if.sink   i_desc,
    mmrc_stream_if.source o_region
);

    t_in_stage w_stage;
    t_pair     w_pair;
    t_q_status w_qstat;

    // Input register: hold one descriptor until the queue has room
    mmrc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_desc.valid),
        .i_desc  (i_desc.payload),
        .o_ready (i_desc.ready),
        .i_adv   (w_qstat.adv),
        .o_stage (w_stage)
    );

    // Held region, running total and the regions this descriptor flushes
    mmrc_merge #(
        .ADDR_BITS  (ADDR_BITS),
        .PAGE_SHIFT (PAGE_SHIFT)
    ) u_merge (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stage (w_stage),
        .i_adv   (w_qstat.adv),
        .o_pair  (w_pair)
    );

    // Two-entry output queue; advance the pipe only when all new regions fit
    mmrc_out_queue u_out_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (w_stage.valid),
        .i_pair     (w_pair),
        .o_status   (w_qstat),
        .o_valid    (o_region.valid),
        .i_ready    (o_region.ready),
        .o_region   (o_region.payload)
    );

`ifndef ASSERT_OFF
    // Advance only with a descriptor in the input register
    a_adv_needs_desc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qstat.adv |-> w_stage.valid)
        else $error("advance without a registered descriptor");

    // Queue never holds more than two regions
    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_qstat.cnt != 2'd3)
        else $error("output queue overflow");

    // Total is reported only on the final region
    a_total_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_region.valid && !o_region.payload.last_region) |->
            (o_region.payload.total_mb == '0))
        else $error("total reported on a non-final region");

    // After a final descriptor retires, no region is held to flush
    a_map_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_qstat.adv && w_stage.desc.last_desc) |=> !w_pair.v0)
        else $error("held region survived the end of the map");
`endif

endmodule
